[design/pmt_pkg.sv]
// Package for the IPv4 prefix match table: action and status codes,
// the table write command type and the prefix mask function.
// No dependencies.
package pmt_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MATCH   = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    typedef struct packed {
        logic              clear;
        logic              insert;
        logic [ADDR_W-1:0] value;
        logic [LEN_W-1:0]  len;
    } pmt_wr_t;

    // leading-ones mask; lengths of 32 and above give all ones
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len >= MAX_LEN) begin
            m = '1;
        end else begin
            m = ~({ADDR_W{1'b1}} >> len);
        end
        return m;
    endfunction

endpackage

[design/ipv4_prefix_match_table_core.sv]
// IPv4 prefix match table, top level: input register, entry array with
// parallel compare, result register. Depends on pmt_pkg and pmt_entry_array.
//
// Takes one item per cycle while the output side is not stalled and
// returns one status per item via the input and result registers. All
// ENTRIES stored prefixes are compared in parallel between the input
// register and the result register, and a table update lands at the same
// edge as its result, so the next item already sees it.
// Reset clears the valid bits at once; there is no clearing pass.
module ipv4_prefix_match_table_core
    import pmt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // addr[31:0], prefix_len[37:32], zero pad
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // status[1:0], zero pad
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    logic              in_valid_reg;
    logic [1:0]        in_action_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [LEN_W-1:0]  in_len_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [1:0]        status_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              advance;
    logic              s_xfer;
    logic [LEN_W-1:0]  sat_len;
    logic [ADDR_W-1:0] key_value;
    pmt_wr_t           wr;
    logic              hit;
    logic              dup;
    logic              full;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == FULL_CNT);

    assign sat_len   = (in_len_reg > MAX_LEN) ? MAX_LEN : in_len_reg;
    assign key_value = in_addr_reg & len_mask(sat_len);

    always_comb begin
        wr.clear    = advance && (in_action_reg == ACT_CLEAR);
        wr.value    = key_value;
        wr.len      = sat_len;
        wr.insert   = advance && (in_action_reg == ACT_INSERT) && !dup && !full;
        count_next  = count_reg;
        status_next = ST_DONE;
        case (in_action_reg)
            ACT_CLEAR: begin
                count_next = '0;
            end
            ACT_INSERT: begin
                if (!dup) begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ACT_QUERY: begin
                status_next = hit ? ST_MATCH : ST_NOMATCH;
            end
            default: begin
                status_next = ST_DONE;
            end
        endcase
    end

    pmt_entry_array #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_array (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr          (wr),
        .wr_idx      (count_reg[IDX_W-1:0]),
        .key_value   (key_value),
        .key_len     (sat_len),
        .lookup_addr (in_addr_reg),
        .hit         (hit),
        .dup         (dup)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_action_reg <= s_axis_tuser;
            in_addr_reg   <= s_axis_tdata[31:0];
            in_len_reg    <= s_axis_tdata[37:32];
        end
        if (advance) begin
            out_status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_status_reg};

endmodule

[design/pmt_entry_array.sv]
// Prefix entry storage with a parallel compare cell per entry.
// Reports address hit and exact duplicate; depends on pmt_pkg.
module pmt_entry_array
    import pmt_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int IDX_W   = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pmt_wr_t           wr,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [ADDR_W-1:0] key_value,
    input  logic [LEN_W-1:0]  key_len,
    input  logic [ADDR_W-1:0] lookup_addr,
    output logic              hit,
    output logic              dup
);

    logic [ADDR_W-1:0]  value_reg [ENTRIES];
    logic [LEN_W-1:0]   len_reg   [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] dup_vec;

    always_comb begin
        valid_next = valid_reg;
        if (wr.clear) begin
            valid_next = '0;
        end else if (wr.insert) begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.insert) begin
            value_reg[wr_idx] <= wr.value;
            len_reg[wr_idx]   <= wr.len;
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = valid_reg[i] &&
                         ((lookup_addr & len_mask(len_reg[i])) == value_reg[i]);
            dup_vec[i] = valid_reg[i] && (value_reg[i] == key_value) &&
                         (len_reg[i] == key_len);
        end
    end

    assign hit = |hit_vec;
    assign dup = |dup_vec;

endmodule

[sim/tb_ipv4_prefix_match_table_core.sv]
// Testbench for ipv4_prefix_match_table_core: directed and random clear, insert, query
// and unused-action transfers, each status checked against a scoreboard prefix table.
// Depends on pmt_pkg and the design sources.
module tb_ipv4_prefix_match_table_core
    import pmt_pkg::*;
();

    localparam int          ENTRIES     = 64;
    localparam int          N_RANDOM    = 400;
    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // addr[31:0], prefix_len[37:32], zero pad
    logic [1:0]  s_axis_tuser = '0;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // status[1:0], zero pad

    int hold_left = 0;
    int tx_calm = 0;
    int cycles = 0;

    ipv4_prefix_match_table_core #(.ENTRIES(ENTRIES)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    class prefix_scoreboard;
        logic [31:0] pfx_val[ENTRIES];
        logic [5:0]  pfx_len[ENTRIES];
        int          n_used;
        logic [1:0]  status_q[$];
        int          n_results;
        int          n_errors;

        function new();
            n_used = 0;
            n_results = 0;
            n_errors = 0;
        endfunction

        // len must already be saturated to 32
        function logic [31:0] lead_mask(input logic [5:0] len);
            return 32'(64'hFFFF_FFFF_0000_0000 >> len);
        endfunction

        task report(input string msg);
            n_errors++;
            $display("mismatch: %s", msg);
        endtask

        function void note_input(input logic [1:0] act, input logic [31:0] addr,
                                 input logic [5:0] len_in);
            logic [5:0]  len;
            logic [31:0] val;
            logic [1:0]  st;
            bit          hit;
            len = (len_in > 6'd32) ? 6'd32 : len_in;
            st = ST_DONE;
            hit = 1'b0;
            case (act)
                ACT_CLEAR: begin
                    n_used = 0;
                end
                ACT_INSERT: begin
                    val = addr & lead_mask(len);
                    for (int i = 0; i < n_used; i++)
                        if (pfx_val[i] == val && pfx_len[i] == len) hit = 1'b1;
                    if (!hit) begin
                        if (n_used == ENTRIES) begin
                            st = ST_FULL;
                        end else begin
                            pfx_val[n_used] = val;
                            pfx_len[n_used] = len;
                            n_used++;
                        end
                    end
                end
                ACT_QUERY: begin
                    for (int i = 0; i < n_used; i++)
                        if ((addr & lead_mask(pfx_len[i])) == pfx_val[i]) hit = 1'b1;
                    st = hit ? ST_MATCH : ST_NOMATCH;
                end
                default: begin
                    st = ST_DONE;
                end
            endcase
            status_q.push_back(st);
        endfunction

        task check_result(input logic [1:0] status);
            logic [1:0] exp_st;
            n_results++;
            if (status_q.size() == 0) begin
                report($sformatf("result %0d: status %0d with nothing outstanding",
                                 n_results, status));
            end else begin
                exp_st = status_q.pop_front();
                if (status !== exp_st)
                    report($sformatf("result %0d: status %0d, expected %0d",
                                     n_results, status, exp_st));
            end
        endtask
    endclass

    prefix_scoreboard sb;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(8, 40);
        calm = $urandom_range(30, 120);
        return 0;
    endfunction

    initial begin : receiver
        int rx_wait;
        int rx_calm;
        rx_wait = 0;
        rx_calm = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_wait = next_gap(rx_calm);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[1:0]);
    end

    task automatic send_item(input logic [1:0] act, input logic [31:0] addr,
                             input logic [5:0] len);
        int gap;
        gap = next_gap(tx_calm);
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, len, addr};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(act, addr, len);
    endtask

    function automatic logic [5:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 6'd0;
        if (r < 10) return 6'($urandom_range(33, 63));
        if (r < 20) return 6'($urandom_range(1, 7));
        return 6'($urandom_range(8, 32));
    endfunction

    // random address, or with hit_pct odds one under a stored prefix, sometimes with one prefix bit flipped
    function automatic logic [31:0] pick_addr(input int hit_pct);
        logic [31:0] a;
        logic [31:0] m;
        int          i;
        int          b;
        a = $urandom;
        if (sb.n_used > 0 && $urandom_range(0, 99) < hit_pct) begin
            i = $urandom_range(0, sb.n_used - 1);
            m = sb.lead_mask(sb.pfx_len[i]);
            a = sb.pfx_val[i] | (a & ~m);
            if (sb.pfx_len[i] > 0 && $urandom_range(0, 2) == 0) begin
                b = $urandom_range(0, sb.pfx_len[i] - 1);
                a[31 - b] = ~a[31 - b];
            end
        end
        return a;
    endfunction

    initial begin : stimulus
        int  n_sent;
        int  target;
        int  ins;
        int  r;
        bit  first;
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(ACT_QUERY,  32'h0000_0000, 6'd0);
        send_item(ACT_INSERT, 32'h0A12_3456, 6'd8);
        send_item(ACT_QUERY,  32'h0AFF_FFFF, 6'd0);
        send_item(ACT_QUERY,  32'h0B00_0000, 6'd0);
        send_item(ACT_INSERT, 32'h0A01_FFFF, 6'd16);
        send_item(ACT_QUERY,  32'h0A99_0000, 6'd0);   // shorter prefix still hits
        send_item(ACT_INSERT, 32'h0AAB_CDEF, 6'd8);   // already stored
        send_item(ACT_INSERT, 32'hC0A8_0101, 6'd32);
        send_item(ACT_QUERY,  32'hC0A8_0101, 6'd0);
        send_item(ACT_QUERY,  32'hC0A8_0100, 6'd0);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 6'd63);  // length saturates
        send_item(ACT_QUERY,  32'hFFFF_FFFF, 6'd0);
        send_item(ACT_INSERT, 32'h0000_0000, 6'd33);
        send_item(ACT_QUERY,  32'h0000_0000, 6'd0);
        send_item(ACT_QUERY,  32'h0000_0001, 6'd63);  // length ignored on query
        send_item(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);
        send_item(ACT_INSERT, 32'h1234_5678, 6'd0);   // matches everything
        send_item(ACT_QUERY,  32'h7F00_0001, 6'd0);
        send_item(ACT_CLEAR,  32'hFFFF_FFFF, 6'd63);
        send_item(ACT_QUERY,  32'hFFFF_FFFF, 6'd0);
        send_item(ACT_INSERT, 32'h8000_0000, 6'd1);
        send_item(ACT_QUERY,  32'h8000_0001, 6'd0);
        send_item(ACT_QUERY,  32'h7FFF_FFFF, 6'd0);

        hold_left = 300;
        n_sent = 0;
        first = 1'b1;
        while (n_sent < N_RANDOM) begin
            target = (first || $urandom_range(0, 3) == 0) ? 80 : $urandom_range(2, 20);
            first = 1'b0;
            send_item(ACT_CLEAR, $urandom, 6'($urandom));
            n_sent++;
            ins = 0;
            while (ins < target && n_sent < N_RANDOM) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    send_item(ACT_INSERT, pick_addr(target > 20 ? 5 : 25), pick_len());
                    ins++;
                end else if (r < 93) begin
                    send_item(ACT_QUERY, pick_addr(60), 6'($urandom));
                end else begin
                    send_item(2'($urandom), $urandom, 6'($urandom));
                end
                n_sent++;
            end
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        while (sb.status_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
